// ===== rtl/sha_pkg.sv =====
// SHA-256 stream hasher package: payload structs, constants, round functions.
// No dependencies.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// Top level of the streaming SHA-256 hasher.
// Depends on sha_pkg, sha_in_fifo and sha_core.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------
//  request   | i_push / o_full     | i_item  (byte, present, last)
//  result    | o_empty / i_pop     | o_item  (word, index, last)
//
// A byte request is taken while the core is idle; a request that completes a block
// starts a compression of 64 rounds, one per cycle, of the single round unit. A last
// request adds a padding and a length step, one or two compressions and eight result
// pops. Reset is synchronous, active low, and restores the initial chaining value.
// A two-entry queue lets requests arrive while the core works or while digest words
// wait to be popped.
module sha256_stream_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sha_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output sha_pkg::t_out_item o_item
);
    logic              q_valid, q_pop;
    sha_pkg::t_in_item q_item;

    // front: request queue
    sha_in_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_item(i_item), .o_full(o_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_item(q_item)
    );

    // back: packing, padding, compression, digest
    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_item(q_item), .o_pop(q_pop),
        .o_empty(o_empty), .i_pop(i_pop), .o_item(o_item)
    );
endmodule

// ===== rtl/sha_in_fifo.sv =====
// Two-entry request queue between the front port and the hashing core.
// Depends on sha_pkg.
module sha_in_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sha_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sha_pkg::t_in_item o_item
);
    sha_pkg::t_in_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== rtl/sha_core.sv =====
// Hashing core: byte packing, padding, 64-round compression, digest output.
// Depends on sha_pkg.
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sha_pkg::t_in_item  i_item,
    output logic               o_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output sha_pkg::t_out_item o_item
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_LEN  = 5'b00100,
        S_RUN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_buf [16];
    logic [31:0] n_buf [16];
    logic [31:0] r_h   [8];
    logic [31:0] r_v   [8];
    logic [31:0] n_v   [8];
    logic [31:0] r_w   [16];
    logic [63:0] r_bits;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic        r_final;   // compression ends the message
    logic        r_more;    // after this compression a length block follows
    logic        r_feed;    // compression was started from idle by a full block on the last item
    logic [2:0]  r_oidx;

    // byte insert helper values
    logic [3:0]  wsel;
    logic [1:0]  lane;
    logic [31:0] shifted;
    logic [31:0] t1, t2, wnew, wr_cur;

    assign wsel    = r_fill[5:2];
    assign lane    = r_fill[1:0];

    always_comb begin
        wnew = sha_pkg::ssig1(r_w[4'(r_rnd - 6'd2)]) + r_w[4'(r_rnd - 6'd7)]
             + sha_pkg::ssig0(r_w[4'(r_rnd - 6'd15)]) + r_w[r_rnd[3:0]];
        if (r_rnd < 6'd16) wr_cur = r_w[r_rnd[3:0]];
        else               wr_cur = wnew;
        t1 = r_v[7] + sha_pkg::bsig1(r_v[4])
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha_pkg::ROUND_K[r_rnd] + wr_cur;
        t2 = sha_pkg::bsig0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        // working variables after this round
        for (int k = 7; k > 0; k--) n_v[k] = r_v[k - 1];
        n_v[4] = r_v[3] + t1;
        n_v[0] = t1 + t2;
    end

    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign o_empty = (r_state != S_OUT);
    assign o_item  = '{digest_word: r_h[r_oidx], word_index: r_oidx,
                       last_word: (r_oidx == 3'd7)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                if (i_item.byte_present && r_fill == 6'd63) n_state = S_RUN;
                else if (i_item.last_item) n_state = S_PAD;
            end
            S_PAD:  n_state = (r_fill == 6'd63 || r_fill > 6'd55) ? S_RUN : S_LEN;
            S_LEN:  n_state = S_RUN;
            S_RUN:  if (r_rnd == 6'd63) begin
                if (r_more) n_state = S_LEN;
                else if (r_final) n_state = S_OUT;
                else if (r_feed) n_state = S_PAD;   // byte filled block on last item
                else n_state = S_IDLE;
            end
            S_OUT:  if (i_pop && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        shifted = 32'(i_item.data_byte) << (5'd24 - {lane, 3'b000});
    end

    // next block buffer; the schedule loads from it when a compression starts
    always_comb begin
        n_buf = r_buf;
        case (r_state)
            S_IDLE: if (i_valid && i_item.byte_present) begin
                if (lane == 2'd0) n_buf[wsel] = shifted;
                else              n_buf[wsel] = r_buf[wsel] | shifted;
            end
            S_PAD: begin
                for (int k = 0; k < 16; k++) begin
                    if (4'(k) == wsel) begin
                        if (lane == 2'd0) n_buf[k] = {sha_pkg::PAD_BYTE, 24'd0};
                        else n_buf[k] = r_buf[k] |
                            (32'(sha_pkg::PAD_BYTE) << (5'd24 - {lane, 3'b000}));
                    end else if (4'(k) > wsel) n_buf[k] = 32'd0;
                end
            end
            S_LEN: begin
                for (int k = 0; k < 14; k++)
                    if (r_more) n_buf[k] = 32'd0;
                n_buf[14] = r_bits[63:32];
                n_buf[15] = r_bits[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload
        r_buf <= n_buf;
        if (n_state == S_RUN && r_state != S_RUN) begin
            r_v <= r_h;
            r_w <= n_buf;
        end
        if (r_state == S_RUN) begin
            if (r_rnd >= 6'd16) r_w[r_rnd[3:0]] <= wnew;
            r_v <= n_v;
        end

        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h <= sha_pkg::INIT_H;
            r_bits <= 64'd0; r_fill <= 6'd0; r_rnd <= 6'd0;
            r_final <= 1'b0; r_more <= 1'b0; r_feed <= 1'b0; r_oidx <= 3'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_final <= 1'b0; r_more <= 1'b0;
                    r_feed  <= i_item.last_item;
                    if (i_item.byte_present) begin
                        r_bits <= r_bits + 64'd8;
                        r_fill <= r_fill + 6'd1;
                    end
                end
                S_PAD: begin
                    r_feed <= 1'b0;
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_more <= 1'b1;       // pad byte filled block
                    else if (r_fill > 6'd55) r_more <= 1'b1;
                end
                S_LEN: begin
                    r_more <= 1'b0; r_final <= 1'b1;
                end
                S_RUN: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63)
                        for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + n_v[k];
                end
                S_OUT: if (i_pop) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_h <= sha_pkg::INIT_H;
                        r_bits <= 64'd0; r_fill <= 6'd0; r_final <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
